@@ hw/rtl/kcf_pkg.sv @@
// Shared widths, codes and types of the key chatter filter.
package kcf_pkg;

  localparam int unsigned TypeW   = 16;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned ValW    = 32;
  localparam int unsigned SecW    = 32;
  localparam int unsigned UsecW   = 20;
  localparam int unsigned ThreshW = 24;
  localparam int unsigned TimeW   = 52;

  localparam int unsigned NumKeysDefault = 768;
  localparam int unsigned IdxWDefault    = $clog2(NumKeysDefault);
  localparam int unsigned HistDepth      = 3;

  localparam logic [TypeW-1:0]      KeyEventType = TypeW'(1);
  localparam logic [TimeW-1:0]      UsecPerSec   = TimeW'(1000000);
  localparam logic [ThreshW-1:0]    ThreshReset  = ThreshW'(30000);
  localparam logic signed [ValW-1:0] ValRelease  = ValW'(0);
  localparam logic signed [ValW-1:0] ValPress    = ValW'(1);
  localparam logic signed [ValW-1:0] ValRepeat   = ValW'(2);

  typedef struct packed {
    logic             sup;
    logic [TimeW-1:0] rel_time;
  } kcf_entry_t;

  typedef struct packed {
    logic [TypeW-1:0]       etype;
    logic [CodeW-1:0]       code;
    logic signed [ValW-1:0] value;
    logic [SecW-1:0]        sec;
    logic [UsecW-1:0]       usec;
  } kcf_evt_t;

endpackage

@@ hw/rtl/kcf_state_mem.sv @@
// Per-key state memory with a clearing pass after reset and a registered read port.
module kcf_state_mem #(
  parameter int unsigned NumKeys = kcf_pkg::NumKeysDefault,
  parameter int unsigned IdxW    = kcf_pkg::IdxWDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  output logic               busy_o,
  input  logic               rd_en_i,
  input  logic [IdxW-1:0]    rd_addr_i,
  output kcf_pkg::kcf_entry_t rd_data_o,
  input  logic               wr_en_i,
  input  logic [IdxW-1:0]    wr_addr_i,
  input  kcf_pkg::kcf_entry_t wr_data_i
);
  import kcf_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumKeys - 1);

  kcf_entry_t      mem_q [NumKeys];
  kcf_entry_t      rd_data_q;
  logic            busy_q;
  logic [IdxW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_cnt_q <= '0;
    end else if (busy_q) begin
      if (clr_cnt_q == LastIdx) begin
        busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_cnt_q] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign busy_o    = busy_q;
  assign rd_data_o = rd_data_q;

`ifndef SYNTHESIS
  a_no_write_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !wr_en_i) else $error("Write during clearing pass.");
  a_no_read_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !rd_en_i) else $error("Read during clearing pass.");
  a_clear_covers_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(clr_cnt_q) == LastIdx)
    else $error("Clearing pass ended early.");
`endif

endmodule

@@ hw/rtl/key_chatter_filter.sv @@
// Top level of the key chatter filter: decode, timestamp pipeline and per-key decision.
//
// Input words arrive on the in_valid_i/in_ready_o channel and are either
// forwarded unchanged on the out_valid_o/out_ready_i channel or dropped.
// The threshold register is written through cfg_valid_i/cfg_ready_o with the
// data on threshold_us_i; it may only be written while the filter is idle.
// A forwarded word passes these registers in order: the word and its state
// memory read, the seconds product, the microsecond sum with the threshold
// difference, and the output register, which takes the per-key decision.
// One word per cycle is sustained while out_ready_i stays high, set by the
// single read-modify-write of the per-key state memory, with recent writes
// forwarded to the decision stage.
// After reset the state memory is cleared one entry per cycle, from entry 0
// to entry NUM_KEYS-1; in_ready_o stays low until that pass ends.
// When the receiver stalls, words collect in the pipeline stages and
// in_ready_o drops only once every stage is occupied.
module key_chatter_filter #(
  parameter int unsigned NUM_KEYS = kcf_pkg::NumKeysDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [kcf_pkg::ThreshW-1:0]        threshold_us_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [kcf_pkg::TypeW-1:0]          event_type_i,
  input  logic [kcf_pkg::CodeW-1:0]          key_code_i,
  input  logic signed [kcf_pkg::ValW-1:0]    key_value_i,
  input  logic [kcf_pkg::SecW-1:0]           time_sec_i,
  input  logic [kcf_pkg::UsecW-1:0]          time_usec_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [kcf_pkg::TypeW-1:0]          out_event_type_o,
  output logic [kcf_pkg::CodeW-1:0]          out_key_code_o,
  output logic signed [kcf_pkg::ValW-1:0]    out_key_value_o,
  output logic [kcf_pkg::SecW-1:0]           out_time_sec_o,
  output logic [kcf_pkg::UsecW-1:0]          out_time_usec_o
);
  import kcf_pkg::*;

  localparam int unsigned IdxW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [CodeW:0] NumKeysW = NUM_KEYS[CodeW:0];

  typedef enum logic [1:0] {
    KindOther,
    KindPress,
    KindRelease,
    KindRepeat
  } kind_e;

  logic [ThreshW-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThreshReset;
    end else if (cfg_valid_i) begin
      thr_q <= threshold_us_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  logic       v1_q, v2_q, v3_q, ov_q;
  logic       en_o, en3, en2, en1, acc;
  logic       mem_busy;
  kcf_evt_t   in_evt, evt1_q, evt2_q, evt3_q, out_q;
  kind_e      kind_d, kind1_q, kind2_q, kind3_q;
  logic       in_key;
  kcf_entry_t rd_data, ent2_q, ent3_q;
  logic [TimeW-1:0] prod2_q, now2, now3_q;
  logic [TimeW+1:0] nt_d, nt3_q;

  assign en_o       = !ov_q || out_ready_i;
  assign en3        = !v3_q || en_o;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1 && !mem_busy;
  assign acc        = in_valid_i && in_ready_o;

  assign in_evt.etype = event_type_i;
  assign in_evt.code  = key_code_i;
  assign in_evt.value = key_value_i;
  assign in_evt.sec   = time_sec_i;
  assign in_evt.usec  = time_usec_i;

  assign in_key = (event_type_i == KeyEventType) && ({1'b0, key_code_i} < NumKeysW);

  always_comb begin
    kind_d = KindOther;
    if (in_key) begin
      if (key_value_i == ValPress) begin
        kind_d = KindPress;
      end else if (key_value_i == ValRelease) begin
        kind_d = KindRelease;
      end else if (key_value_i == ValRepeat) begin
        kind_d = KindRepeat;
      end
    end
  end

  assign now2 = prod2_q + TimeW'(evt2_q.usec);
  assign nt_d = {2'b00, now2} - (TimeW+2)'(thr_q);

  // Pipeline control and payload stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= acc;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      evt1_q  <= in_evt;
      kind1_q <= kind_d;
    end
    if (en2 && v1_q) begin
      evt2_q  <= evt1_q;
      kind2_q <= kind1_q;
      ent2_q  <= rd_data;
      prod2_q <= TimeW'(evt1_q.sec) * UsecPerSec;
    end
    if (en3 && v2_q) begin
      evt3_q  <= evt2_q;
      kind3_q <= kind2_q;
      ent3_q  <= ent2_q;
      now3_q  <= now2;
      nt3_q   <= nt_d;
    end
  end

  // Decision stage with forwarding of the most recent writes.
  logic [IdxW-1:0] key3;
  logic [IdxW-1:0] hist_key_q [HistDepth];
  kcf_entry_t      hist_dat_q [HistDepth];
  logic [HistDepth-1:0] hist_vld_q;
  kcf_entry_t      ent;
  kcf_entry_t      wdata;
  logic            lt, fwd3, wr3, mem_wr_en;

  assign key3 = evt3_q.code[IdxW-1:0];

  always_comb begin
    ent = ent3_q;
    for (int i = HistDepth - 1; i >= 0; i--) begin
      if (hist_vld_q[i] && (hist_key_q[i] == key3)) begin
        ent = hist_dat_q[i];
      end
    end
  end

  assign lt = $signed(nt3_q) < $signed({2'b00, ent.rel_time});

  always_comb begin
    fwd3  = 1'b1;
    wr3   = 1'b0;
    wdata = ent;
    case (kind3_q)
      KindPress: begin
        wr3 = 1'b1;
        if ((ent.rel_time != '0) && lt) begin
          wdata.sup = 1'b1;
          fwd3      = 1'b0;
        end else begin
          wdata.sup = 1'b0;
        end
      end
      KindRelease: begin
        wr3            = 1'b1;
        wdata.rel_time = now3_q;
        wdata.sup      = 1'b0;
        fwd3           = !ent.sup;
      end
      KindRepeat: begin
        fwd3 = !ent.sup;
      end
      default: begin
      end
    endcase
  end

  assign mem_wr_en = v3_q && en3 && wr3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
    end else if (mem_wr_en) begin
      hist_vld_q <= {hist_vld_q[HistDepth-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      hist_key_q[0] <= key3;
      hist_dat_q[0] <= wdata;
      for (int i = 1; i < HistDepth; i++) begin
        hist_key_q[i] <= hist_key_q[i-1];
        hist_dat_q[i] <= hist_dat_q[i-1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en_o) begin
      ov_q <= v3_q && fwd3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && v3_q && fwd3) begin
      out_q <= evt3_q;
    end
  end

  assign out_valid_o      = ov_q;
  assign out_event_type_o = out_q.etype;
  assign out_key_code_o   = out_q.code;
  assign out_key_value_o  = out_q.value;
  assign out_time_sec_o   = out_q.sec;
  assign out_time_usec_o  = out_q.usec;

  kcf_state_mem #(
    .NumKeys (NUM_KEYS),
    .IdxW    (IdxW)
  ) u_state_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .busy_o    (mem_busy),
    .rd_en_i   (acc),
    .rd_addr_i (key_code_i[IdxW-1:0]),
    .rd_data_o (rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (key3),
    .wr_data_i (wdata)
  );

`ifndef SYNTHESIS
  a_ready_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mem_busy) else $error("Input ready during clearing pass.");
  a_release_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en3 && (kind3_q == KindRelease)) |-> mem_wr_en)
    else $error("Release word left the decision stage without a write.");
  a_out_from_stage3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(v3_q)) else $error("Output word without a source.");
`endif

endmodule
